// ===== rtl/columnar_transposition_macros.svh =====
// assertion macros shared by the columnar transposition rtl
`ifndef COLUMNAR_TRANSPOSITION_MACROS_SVH
`define COLUMNAR_TRANSPOSITION_MACROS_SVH

// property a implies b in the same cycle
`define CT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// property a implies b in the next cycle
`define CT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/ctrans_pkg.sv =====
// shared types and constants for the columnar transposition block
package ctrans_pkg;

  localparam int unsigned CHAR_W    = 8;
  localparam int unsigned CFG_W     = 64;
  localparam int unsigned KEY_CHARS = 16;
  localparam int unsigned KEY_LEN_W = 5;

  localparam logic [CHAR_W-1:0] PAD_CHAR = 8'h5F;

  typedef enum logic [1:0] {
    CFG_DECRYPT_MODE = 2'd0,
    CFG_KEY_LEN      = 2'd1,
    CFG_KEY_LOW      = 2'd2,
    CFG_KEY_HIGH     = 2'd3
  } cfg_idx_e;

endpackage

// ===== rtl/ctrans_ram.sv =====
// generic single write port ram with registered read
module ctrans_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/columnar_transposition.sv =====
// Columnar transposition cipher. Message bytes stream in one word per cycle while the
// block is idle and are stored in a grid ram; the word marked tlast starts the output
// run. The block then sizes the grid with one adder, ranks the key through one byte
// comparator, and emits the text one grid cell at a time, each cell read in S_RD through
// the ram's registered read and handled in S_EMIT (decrypt skips padding cells). Input
// is not ready from the final byte until the run is handed over; an overflowing message
// yields one word with tuser set, loaded from S_OVF once the output register is free.
module columnar_transposition #(
  parameter int unsigned KEY_MAX    = 16,
  parameter int unsigned GRID_CELLS = 64
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // config write port
  input  logic                                   cfg_we_i,
  input  ctrans_pkg::cfg_idx_e                   cfg_addr_i,
  input  logic [ctrans_pkg::CFG_W-1:0]           cfg_wdata_i,
  // input stream
  input  logic                                   s_axis_tvalid_i,
  output logic                                   s_axis_tready_o,
  input  logic [ctrans_pkg::CHAR_W-1:0]          s_axis_tdata_i,   // char_value
  input  logic                                   s_axis_tlast_i,   // end_of_text
  // output stream
  output logic                                   m_axis_tvalid_o,
  input  logic                                   m_axis_tready_i,
  output logic [ctrans_pkg::CHAR_W-1:0]          m_axis_tdata_o,   // out_char
  output logic                                   m_axis_tlast_o,   // last_char
  output logic                                   m_axis_tuser_o    // overflow
);

  import ctrans_pkg::*;

  `include "columnar_transposition_macros.svh"

  localparam int unsigned KW   = $clog2(KEY_MAX);
  localparam int unsigned WW   = $clog2(KEY_MAX + 1);
  localparam int unsigned RW   = $clog2(GRID_CELLS);
  localparam int unsigned CW   = $clog2(GRID_CELLS + 2);
  localparam int unsigned ACCW = $clog2(GRID_CELLS + KEY_MAX + 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_ROWS,
    S_OVF,
    S_RANK,
    S_START,
    S_RD,
    S_EMIT,
    S_FLUSH
  } state_e;

  state_e state_q;

  // config
  logic                  decrypt_q;
  logic [KEY_LEN_W-1:0]  key_len_q;
  logic [CFG_W-1:0]      key_low_q;
  logic [CFG_W-1:0]      key_high_q;

  // load and sizing
  logic [CW-1:0]   count_q;
  logic [CW-1:0]   len_q;
  logic [CW-1:0]   rows_q;
  logic [ACCW-1:0] acc_q;
  logic [WW-1:0]   width_q;
  logic [KW-1:0]   width_m1_q;

  // ranking
  logic [KW-1:0]     i_q;
  logic [KW-1:0]     j_q;
  logic [KW-1:0]     best_q;
  logic [CHAR_W-1:0] best_char_q;
  logic              best_none_q;
  logic [ACCW-1:0]   base_q;
  logic [KEY_MAX-1:0] used_q;
  logic [KW-1:0]     order_q   [KEY_MAX];
  logic [RW-1:0]     colbase_q [KEY_MAX];

  // emission
  logic [KW-1:0]     k_q;
  logic [KW-1:0]     c_q;
  logic [CW-1:0]     r_q;
  logic [ACCW-1:0]   addr_q;
  logic              hold_valid_q;
  logic [CHAR_W-1:0] hold_char_q;

  // output register
  logic              out_valid_q;
  logic [CHAR_W-1:0] out_char_q;
  logic              out_last_q;
  logic              out_ovf_q;

  logic              in_acc;
  logic              can_push;
  logic              out_push;
  logic [CHAR_W-1:0] kc;
  logic              cand;
  logic [KW-1:0]     best_sel;
  logic [CHAR_W-1:0] rdata;
  logic [CHAR_W-1:0] grid_byte;
  logic              keep;
  logic              last_item;
  logic [CW-1:0]     rows_last;
  logic [CHAR_W-1:0] key_bytes [KEY_CHARS];
  int unsigned       wclamp;

  assign in_acc   = s_axis_tvalid_i && s_axis_tready_o;
  assign can_push = !out_valid_q || m_axis_tready_i;

  always_comb begin
    for (int b = 0; b < 8; b++) begin
      key_bytes[b]     = key_low_q[b*8 +: 8];
      key_bytes[b + 8] = key_high_q[b*8 +: 8];
    end
    kc = '0;
    for (int b = 0; b < int'(KEY_CHARS); b++) begin
      if (32'(j_q) == b) begin
        kc = key_bytes[b];
      end
    end
  end

  always_comb begin
    if (key_len_q == '0) begin
      wclamp = 1;
    end else if (32'(key_len_q) > KEY_MAX) begin
      wclamp = KEY_MAX;
    end else begin
      wclamp = 32'(key_len_q);
    end
  end

  assign cand      = !used_q[j_q] && (best_none_q || kc < best_char_q);
  assign best_sel  = cand ? j_q : best_q;
  assign rows_last = rows_q - 1'b1;
  assign grid_byte = (addr_q >= ACCW'(len_q)) ? PAD_CHAR : rdata;
  assign keep      = !decrypt_q || (grid_byte != PAD_CHAR);
  assign last_item = (r_q == rows_last) &&
                     (decrypt_q ? (c_q == width_m1_q) : (k_q == width_m1_q));
  assign out_push  = can_push && ((state_q == S_OVF) ||
                                  ((state_q == S_EMIT) && keep && hold_valid_q) ||
                                  ((state_q == S_FLUSH) && hold_valid_q));

  ctrans_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (GRID_CELLS)
  ) u_grid (
    .clk_i   (clk_i),
    .we_i    (in_acc && (count_q < CW'(GRID_CELLS))),
    .waddr_i (count_q[RW-1:0]),
    .wdata_i (s_axis_tdata_i),
    .re_i    (state_q == S_RD),
    .raddr_i (addr_q[RW-1:0]),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      decrypt_q  <= 1'b0;
      key_len_q  <= KEY_LEN_W'(1);
      key_low_q  <= '0;
      key_high_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CFG_DECRYPT_MODE: decrypt_q  <= cfg_wdata_i[0];
        CFG_KEY_LEN:      key_len_q  <= cfg_wdata_i[KEY_LEN_W-1:0];
        CFG_KEY_LOW:      key_low_q  <= cfg_wdata_i;
        CFG_KEY_HIGH:     key_high_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      count_q      <= '0;
      hold_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
      used_q       <= '0;
      best_none_q  <= 1'b1;
    end else begin
      if (out_valid_q && m_axis_tready_i && !out_push) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            if (s_axis_tlast_i) begin
              len_q      <= (count_q <= CW'(GRID_CELLS)) ? count_q + 1'b1 : count_q;
              count_q    <= '0;
              acc_q      <= '0;
              rows_q     <= '0;
              width_q    <= WW'(wclamp);
              width_m1_q <= KW'(wclamp - 1);
              state_q    <= S_ROWS;
            end else if (count_q <= CW'(GRID_CELLS)) begin
              count_q <= count_q + 1'b1;
            end
          end
        end
        S_ROWS: begin
          if (acc_q < ACCW'(len_q)) begin
            acc_q  <= acc_q + ACCW'(width_q);
            rows_q <= rows_q + 1'b1;
          end else if ((len_q > CW'(GRID_CELLS)) || (acc_q > ACCW'(GRID_CELLS))) begin
            state_q <= S_OVF;
          end else begin
            used_q      <= '0;
            i_q         <= '0;
            j_q         <= '0;
            best_none_q <= 1'b1;
            base_q      <= '0;
            state_q     <= S_RANK;
          end
        end
        S_OVF: begin
          if (can_push) begin
            out_valid_q <= 1'b1;
            out_char_q  <= '0;
            out_last_q  <= 1'b1;
            out_ovf_q   <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        S_RANK: begin
          if (j_q == width_m1_q) begin
            order_q[i_q]        <= best_sel;
            colbase_q[best_sel] <= base_q[RW-1:0];
            used_q[best_sel]    <= 1'b1;
            base_q              <= base_q + ACCW'(rows_q);
            j_q                 <= '0;
            best_none_q         <= 1'b1;
            if (i_q == width_m1_q) begin
              state_q <= S_START;
            end else begin
              i_q <= i_q + 1'b1;
            end
          end else begin
            j_q <= j_q + 1'b1;
            if (cand) begin
              best_q      <= j_q;
              best_char_q <= kc;
              best_none_q <= 1'b0;
            end
          end
        end
        S_START: begin
          k_q          <= '0;
          c_q          <= '0;
          r_q          <= '0;
          hold_valid_q <= 1'b0;
          addr_q       <= decrypt_q ? ACCW'(colbase_q[0]) : ACCW'(order_q[0]);
          state_q      <= S_RD;
        end
        S_RD: begin
          state_q <= S_EMIT;
        end
        S_EMIT: begin
          if (!(keep && hold_valid_q && !can_push)) begin
            if (keep) begin
              hold_char_q  <= grid_byte;
              hold_valid_q <= 1'b1;
              if (hold_valid_q) begin
                out_valid_q <= 1'b1;
                out_char_q  <= hold_char_q;
                out_last_q  <= 1'b0;
                out_ovf_q   <= 1'b0;
              end
            end
            if (last_item) begin
              state_q <= S_FLUSH;
            end else begin
              state_q <= S_RD;
              if (decrypt_q) begin
                if (c_q == width_m1_q) begin
                  c_q    <= '0;
                  r_q    <= r_q + 1'b1;
                  addr_q <= ACCW'(colbase_q[0]) + ACCW'(r_q + 1'b1);
                end else begin
                  c_q    <= c_q + 1'b1;
                  addr_q <= ACCW'(colbase_q[c_q + 1'b1]) + ACCW'(r_q);
                end
              end else begin
                if (r_q == rows_last) begin
                  r_q    <= '0;
                  k_q    <= k_q + 1'b1;
                  addr_q <= ACCW'(order_q[k_q + 1'b1]);
                end else begin
                  r_q    <= r_q + 1'b1;
                  addr_q <= addr_q + ACCW'(width_q);
                end
              end
            end
          end
        end
        S_FLUSH: begin
          if (!hold_valid_q) begin
            state_q <= S_IDLE;
          end else if (can_push) begin
            out_valid_q  <= 1'b1;
            out_char_q   <= hold_char_q;
            out_last_q   <= 1'b1;
            out_ovf_q    <= 1'b0;
            hold_valid_q <= 1'b0;
            state_q      <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_char_q;
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tuser_o  = out_ovf_q;

  `CT_ASSERT_IMP(a_ovf_word, out_valid_q && out_ovf_q, out_last_q && (out_char_q == '0), "overflow word must be last and zero")
  `CT_ASSERT_IMP(a_hold_idle, state_q == S_IDLE, !hold_valid_q, "held byte left over after a run")
  `CT_ASSERT_IMP(a_addr_grid, state_q == S_EMIT, addr_q < ACCW'(GRID_CELLS), "grid address out of range")
  `CT_ASSERT_NXT(a_busy_after_last, in_acc && s_axis_tlast_i, !s_axis_tready_o, "ready right after final byte")

endmodule

// ===== tb/columnar_transposition_check.sv =====
// checker that predicts the cipher output words and compares them with the block
module columnar_transposition_check
  import ctrans_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  cfg_idx_e           cfg_addr_i,
  input  logic [CFG_W-1:0]   cfg_wdata_i,
  input  logic               s_tvalid_i,
  input  logic               s_tready_i,
  input  logic [CHAR_W-1:0]  s_tdata_i,
  input  logic               s_tlast_i,
  input  logic               m_tvalid_i,
  input  logic               m_tready_i,
  input  logic [CHAR_W-1:0]  m_tdata_i,
  input  logic               m_tlast_i,
  input  logic               m_tuser_i,
  output int                 mismatches_o,
  output int                 pending_o,
  output int                 words_o,
  output int                 overflows_o
);

  localparam int unsigned GRID = 64;
  localparam int unsigned KEYS = 16;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
    logic              ovf;
  } cipher_word_t;

  cipher_word_t      cipher_q[$];
  cipher_word_t      want;
  logic [CHAR_W-1:0] text_mem [GRID];
  int unsigned       text_len;
  logic              decrypt_q;
  logic [4:0]        key_len_q;
  logic [63:0]       key_lo_q;
  logic [63:0]       key_hi_q;

  function automatic logic [CHAR_W-1:0] key_byte(int unsigned j);
    if (j < 8) return key_lo_q[8*j +: 8];
    return key_hi_q[8*(j-8) +: 8];
  endfunction

  function automatic logic [CHAR_W-1:0] grid_cell(int unsigned idx, int unsigned len);
    if (idx < len && idx < GRID) return text_mem[idx];
    return PAD_CHAR;
  endfunction

  function automatic void transpose_message(int unsigned len);
    int unsigned       width;
    int unsigned       rows;
    int unsigned       rank [KEYS];
    logic [CHAR_W-1:0] v;
    cipher_word_t      run_q[$];
    cipher_word_t      w;
    width = (key_len_q == 0) ? 1 : ((key_len_q > KEYS) ? KEYS : key_len_q);
    rows  = (len + width - 1) / width;
    if (len > GRID || rows * width > GRID) begin
      cipher_q.push_back('{ch: '0, last: 1'b1, ovf: 1'b1});
      return;
    end
    // stable ascending rank, ties to the lower column
    for (int unsigned c = 0; c < width; c++) begin
      rank[c] = 0;
      for (int unsigned j = 0; j < width; j++)
        if (key_byte(j) < key_byte(c) || (key_byte(j) == key_byte(c) && j < c)) rank[c]++;
    end
    if (!decrypt_q) begin
      for (int unsigned k = 0; k < width; k++)
        for (int unsigned c = 0; c < width; c++)
          if (rank[c] == k)
            for (int unsigned r = 0; r < rows; r++)
              run_q.push_back('{ch: grid_cell(r * width + c, len), last: 1'b0, ovf: 1'b0});
    end else begin
      for (int unsigned r = 0; r < rows; r++)
        for (int unsigned c = 0; c < width; c++) begin
          v = grid_cell(rank[c] * rows + r, len);
          if (v != PAD_CHAR) run_q.push_back('{ch: v, last: 1'b0, ovf: 1'b0});
        end
    end
    foreach (run_q[i]) begin
      w = run_q[i];
      w.last = (i == run_q.size() - 1);
      cipher_q.push_back(w);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cipher_q.delete();
      text_len     = 0;
      decrypt_q    = 1'b0;
      key_len_q    = 5'd1;
      key_lo_q     = '0;
      key_hi_q     = '0;
      mismatches_o = 0;
      pending_o    = 0;
      words_o      = 0;
      overflows_o  = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_addr_i)
          CFG_DECRYPT_MODE: decrypt_q = cfg_wdata_i[0];
          CFG_KEY_LEN:      key_len_q = cfg_wdata_i[4:0];
          CFG_KEY_LOW:      key_lo_q  = cfg_wdata_i;
          CFG_KEY_HIGH:     key_hi_q  = cfg_wdata_i;
          default: ;
        endcase
      end
      if (s_tvalid_i && s_tready_i) begin
        if (text_len < GRID) text_mem[text_len] = s_tdata_i;
        if (text_len <= GRID) text_len++;
        if (s_tlast_i) begin
          transpose_message(text_len);
          text_len = 0;
        end
      end
      if (m_tvalid_i && m_tready_i) begin
        if (cipher_q.size() == 0) begin
          mismatches_o++;
          if (mismatches_o <= 10)
            $display("unexpected word: char %02h last %0b overflow %0b",
                     m_tdata_i, m_tlast_i, m_tuser_i);
        end else begin
          want = cipher_q.pop_front();
          words_o++;
          if (m_tuser_i) overflows_o++;
          if (m_tdata_i !== want.ch || m_tlast_i !== want.last || m_tuser_i !== want.ovf) begin
            mismatches_o++;
            if (mismatches_o <= 10)
              $display("word %0d mismatch: expected char %02h last %0b overflow %0b, got char %02h last %0b overflow %0b",
                       words_o, want.ch, want.last, want.ovf, m_tdata_i, m_tlast_i, m_tuser_i);
          end
        end
      end
      pending_o = cipher_q.size();
    end
  end

endmodule

// ===== tb/columnar_transposition_test.sv =====
// testbench top for the columnar transposition block: stimulus, config phases and verdict
module columnar_transposition_test;
  import ctrans_pkg::*;

  localparam int unsigned ITEM_TARGET   = 480;
  localparam int unsigned STALL_MAX     = 12;
  localparam int unsigned LONG_HOLD     = 400;
  localparam int unsigned SETTLE_CYCLES = 600;
  localparam int unsigned CYCLE_LIMIT   = 400000;

  typedef enum int {TEXT_RANDOM, TEXT_PADDED, TEXT_ALL_PAD, TEXT_LETTERS} text_style_e;

  logic              clk_i           = 1'b0;
  logic              rst_ni          = 1'b0;
  logic              cfg_we_i        = 1'b0;
  cfg_idx_e          cfg_addr_i      = CFG_DECRYPT_MODE;
  logic [CFG_W-1:0]  cfg_wdata_i     = '0;
  logic              s_axis_tvalid_i = 1'b0;
  logic              s_axis_tready_o;
  logic [CHAR_W-1:0] s_axis_tdata_i  = '0;
  logic              s_axis_tlast_i  = 1'b0;
  logic              m_axis_tvalid_o;
  logic              m_axis_tready_i = 1'b0;
  logic [CHAR_W-1:0] m_axis_tdata_o;
  logic              m_axis_tlast_o;
  logic              m_axis_tuser_o;

  int          mismatches;
  int          pending;
  int          words;
  int          overflows;
  int unsigned cycle_count    = 0;
  int unsigned items_sent     = 0;
  int unsigned messages_sent  = 0;
  int unsigned settings_used  = 0;
  int unsigned send_gap_max   = STALL_MAX;

  columnar_transposition dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_addr_i      (cfg_addr_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  columnar_transposition_check u_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_tvalid_i   (s_axis_tvalid_i),
    .s_tready_i   (s_axis_tready_o),
    .s_tdata_i    (s_axis_tdata_i),
    .s_tlast_i    (s_axis_tlast_i),
    .m_tvalid_i   (m_axis_tvalid_o),
    .m_tready_i   (m_axis_tready_i),
    .m_tdata_i    (m_axis_tdata_o),
    .m_tlast_i    (m_axis_tlast_o),
    .m_tuser_i    (m_axis_tuser_o),
    .mismatches_o (mismatches),
    .pending_o    (pending),
    .words_o      (words),
    .overflows_o  (overflows)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic send_char(input logic [CHAR_W-1:0] ch, input logic eot);
    int unsigned gap;
    gap = $urandom_range(0, send_gap_max);
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= ch;
    s_axis_tlast_i  <= eot;
    do @(posedge clk_i); while (!s_axis_tready_o);
    items_sent++;
    if (eot) messages_sent++;
  endtask

  function automatic logic [CHAR_W-1:0] pick_char(text_style_e style);
    case (style)
      TEXT_RANDOM:  return CHAR_W'($urandom_range(0, 255));
      TEXT_PADDED:  return ($urandom_range(0, 1) == 0) ? PAD_CHAR : CHAR_W'($urandom_range(0, 255));
      TEXT_ALL_PAD: return PAD_CHAR;
      default:      return CHAR_W'(8'h61 + $urandom_range(0, 25));
    endcase
  endfunction

  task automatic send_message(int unsigned len, text_style_e style);
    for (int unsigned i = 0; i < len; i++) send_char(pick_char(style), i == len - 1);
  endtask

  // stop offering, wait out every expected word and any silent run still in flight
  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CFG_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
  endtask

  task automatic set_cipher(logic dec, logic [4:0] klen, logic [63:0] lo, logic [63:0] hi);
    drain();
    write_reg(CFG_DECRYPT_MODE, CFG_W'(dec));
    write_reg(CFG_KEY_LEN, CFG_W'(klen));
    write_reg(CFG_KEY_LOW, lo);
    write_reg(CFG_KEY_HIGH, hi);
    cfg_we_i <= 1'b0;
    settings_used++;
  endtask

  function automatic logic [63:0] make_key(int unsigned style);
    logic [63:0] k;
    case (style)
      0:       k = '0;
      1:       k = '1;
      2:       k = {$urandom, $urandom};
      default: for (int i = 0; i < 8; i++) k[8*i +: 8] = 8'(8'h41 + $urandom_range(0, 2));
    endcase
    return k;
  endfunction

  function automatic logic [4:0] pick_key_len();
    case ($urandom_range(0, 7))
      0:       return 5'd0;
      1:       return 5'd1;
      2:       return 5'd16;
      3:       return 5'($urandom_range(17, 31));
      default: return 5'($urandom_range(2, 15));
    endcase
  endfunction

  function automatic int unsigned pick_length();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r == 0) return $urandom_range(65, 70);
    if (r < 3) return $urandom_range(40, 64);
    return $urandom_range(1, 20);
  endfunction

  // output side: random stalls, bursts without stalls, two long hold-offs
  initial begin
    int unsigned hold;
    int unsigned taken;
    int unsigned ready_max;
    taken     = 0;
    ready_max = STALL_MAX;
    @(posedge rst_ni);
    forever begin
      if (taken % 40 == 0) ready_max = ($urandom_range(0, 3) == 0) ? 0 : STALL_MAX;
      hold = (taken == 30 || taken == 260) ? LONG_HOLD : $urandom_range(0, ready_max);
      if (hold > 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (hold) @(posedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid_o);
      taken++;
    end
  end

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: encrypt with a one column grid
    send_char(8'h00, 1'b0);
    send_char(8'hFF, 1'b1);
    send_char(PAD_CHAR, 1'b1);

    // tied key characters, partial last row
    set_cipher(1'b0, 5'd3, 64'h0000_0000_0041_4143, '1);
    for (int i = 0; i < 5; i++) send_char(CHAR_W'(8'h61 + i), i == 4);
    set_cipher(1'b1, 5'd3, 64'h0000_0000_0041_4143, '1);
    for (int i = 0; i < 4; i++) send_char(PAD_CHAR, i == 3);
    send_char(8'h78, 1'b0);
    send_char(PAD_CHAR, 1'b0);
    send_char(8'h79, 1'b0);
    send_char(8'h7A, 1'b0);
    send_char(PAD_CHAR, 1'b0);
    send_char(8'h77, 1'b1);

    // key length saturation and zero length
    set_cipher(1'b1, 5'd31, '1, '0);
    send_char(8'h00, 1'b0);
    send_char(8'h80, 1'b0);
    send_char(8'hFF, 1'b1);
    set_cipher(1'b0, 5'd0, make_key(2), make_key(2));
    send_char(PAD_CHAR, 1'b1);

    // grid boundaries: row overflow, exact fit, too long
    set_cipher(1'b0, 5'd10, make_key(2), make_key(2));
    send_message(61, TEXT_RANDOM);
    set_cipher(1'b1, 5'd16, make_key(3), make_key(3));
    send_message(64, TEXT_LETTERS);
    send_message(67, TEXT_RANDOM);

    while (items_sent < ITEM_TARGET) begin
      send_gap_max = ($urandom_range(0, 3) == 0) ? 0 : STALL_MAX;
      set_cipher(1'($urandom_range(0, 1)), pick_key_len(),
                 make_key($urandom_range(0, 3)), make_key($urandom_range(0, 3)));
      repeat ($urandom_range(3, 6)) send_message(pick_length(), text_style_e'($urandom_range(0, 3)));
    end

    drain();
    $display("sent %0d bytes in %0d messages under %0d key settings", items_sent,
             messages_sent, settings_used);
    $display("checked %0d output words, %0d of them overflow, %0d mismatches", words,
             overflows, mismatches);
    if (mismatches == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
